// ===== sv/uf_pkg.sv =====
// Shared constants, control/status types and helpers for the union-find engine.
package uf_pkg;

    localparam int NODES  = 1024;
    localparam int NODE_W = 10;
    localparam int ADDR_W = $clog2(NODES);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clr_wr;      // write one clearing entry and advance the counter
        logic capture;     // take the input beat
        logic load_cur;    // cur <= start node of the current find
        logic rd_en;       // read parent of cur
        logic set_top;     // top <= cur, cur <= start node again
        logic step_cur;    // cur <= parent just read
        logic wr_comp;     // parent[cur] <= top, cur <= parent just read
        logic end_first;   // ra <= top, move on to the second node
        logic finish;      // load the result, link the roots of a union if they differ
    } uf_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clr_last;    // clearing pass writes its final entry
        logic cur_ok;      // cur has a table entry
        logic rd_is_root;  // parent just read ends the walk
        logic rd_ok;       // parent just read has a table entry
        logic cur_is_top;  // compression has reached the root
        logic second;      // working on the second node of a union
        logic is_union;    // current request is a union
        logic out_free;    // output register can take a result
    } uf_sts_t;

    function automatic logic node_ok(input logic [NODE_W-1:0] node);
        node_ok = (32'(node) < NODES);
    endfunction

endpackage

// ===== sv/uf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module uf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/uf_ctrl.sv =====
// Sequencer for clearing, root walk, path compression and linking.
module uf_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  uf_pkg::uf_sts_t sts,
    output uf_pkg::uf_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_CHECK,
        S_WALK_RD,
        S_WALK_CHK,
        S_COMP_CHK,
        S_COMP_WR,
        S_FIND_END,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_stall_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && !in_stall_reg)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load_cur = 1'b1;
                state_next   = S_CHECK;
            end
            S_CHECK:
            begin
                // a node with no entry is its own root
                if (sts.cur_ok)
                begin
                    state_next = S_WALK_RD;
                end
                else
                begin
                    cmd.set_top = 1'b1;
                    state_next  = S_FIND_END;
                end
            end
            S_WALK_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_WALK_CHK;
            end
            S_WALK_CHK:
            begin
                if (sts.rd_is_root)
                begin
                    cmd.set_top = 1'b1;
                    state_next  = S_COMP_CHK;
                end
                else
                begin
                    cmd.step_cur = 1'b1;
                    state_next   = S_WALK_RD;
                end
            end
            S_COMP_CHK:
            begin
                if (sts.cur_is_top)
                begin
                    state_next = S_FIND_END;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_COMP_WR;
                end
            end
            S_COMP_WR:
            begin
                cmd.wr_comp = 1'b1;
                state_next  = sts.rd_ok ? S_COMP_CHK : S_FIND_END;
            end
            S_FIND_END:
            begin
                if (sts.is_union && !sts.second)
                begin
                    cmd.end_first = 1'b1;
                    state_next    = S_LOAD;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // hold until the output register is free
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            in_stall_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= (state_next != S_IDLE);
        end
    end

    assign in_stall = in_stall_reg;

endmodule

// ===== sv/uf_dp.sv =====
// Datapath: request registers, walk pointers, parent table and result register.
module uf_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd,
    input  logic [uf_pkg::NODE_W-1:0] first_node,
    input  logic [uf_pkg::NODE_W-1:0] second_node,
    output logic [uf_pkg::NODE_W-1:0] root_node,
    output logic                      merged,
    output logic                      out_valid,
    input  logic                      out_stall,
    input  uf_pkg::uf_cmd_t           ctl,
    output uf_pkg::uf_sts_t           sts
);

    logic                      op_reg;
    logic [uf_pkg::NODE_W-1:0] a_reg;
    logic [uf_pkg::NODE_W-1:0] b_reg;
    logic [uf_pkg::NODE_W-1:0] cur_reg;
    logic [uf_pkg::NODE_W-1:0] top_reg;
    logic [uf_pkg::NODE_W-1:0] ra_reg;
    logic [uf_pkg::NODE_W-1:0] root_reg;
    logic                      merged_reg;
    logic                      second_reg;
    logic                      out_valid_reg;
    logic [uf_pkg::ADDR_W-1:0] clr_cnt_reg;

    logic                      second_next;
    logic                      out_valid_next;
    logic [uf_pkg::ADDR_W-1:0] clr_cnt_next;

    logic [uf_pkg::NODE_W-1:0] start_node;
    logic [uf_pkg::NODE_W-1:0] rdata;
    logic                      link;
    logic                      ram_we;
    logic [uf_pkg::ADDR_W-1:0] ram_waddr;
    logic [uf_pkg::NODE_W-1:0] ram_wdata;

    assign start_node = second_reg ? b_reg : a_reg;

    // a union whose roots differ and both have entries
    assign link = op_reg && (ra_reg != top_reg)
                  && uf_pkg::node_ok(ra_reg) && uf_pkg::node_ok(top_reg);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = uf_pkg::ADDR_W'(cur_reg);
        ram_wdata = top_reg;
        if (ctl.clr_wr)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = uf_pkg::NODE_W'(clr_cnt_reg);
        end
        else if (ctl.wr_comp)
        begin
            ram_we = 1'b1;
        end
        else if (ctl.finish && link)
        begin
            ram_we    = 1'b1;
            ram_waddr = uf_pkg::ADDR_W'(ra_reg);
        end
    end

    uf_ram #(
        .WIDTH (uf_pkg::NODE_W),
        .DEPTH (uf_pkg::NODES)
    ) u_parent (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ctl.rd_en),
        .raddr (uf_pkg::ADDR_W'(cur_reg)),
        .rdata (rdata)
    );

    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        if (ctl.clr_wr)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end

        second_next = second_reg;
        if (ctl.capture)
        begin
            second_next = 1'b0;
        end
        else if (ctl.end_first)
        begin
            second_next = 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (ctl.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            second_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            second_reg    <= second_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            op_reg <= cmd;
            a_reg  <= first_node;
            b_reg  <= second_node;
        end
        if (ctl.load_cur)
        begin
            cur_reg <= start_node;
        end
        else if (ctl.set_top)
        begin
            // compression restarts from the start node
            top_reg <= cur_reg;
            cur_reg <= start_node;
        end
        else if (ctl.step_cur || ctl.wr_comp)
        begin
            cur_reg <= rdata;
        end
        if (ctl.end_first)
        begin
            ra_reg <= top_reg;
        end
        if (ctl.finish)
        begin
            root_reg   <= top_reg;
            merged_reg <= link;
        end
    end

    assign sts.clr_last   = (32'(clr_cnt_reg) == uf_pkg::NODES - 1);
    assign sts.cur_ok     = uf_pkg::node_ok(cur_reg);
    assign sts.rd_is_root = (rdata == cur_reg) || !uf_pkg::node_ok(rdata);
    assign sts.rd_ok      = uf_pkg::node_ok(rdata);
    assign sts.cur_is_top = (cur_reg == top_reg);
    assign sts.second     = second_reg;
    assign sts.is_union   = op_reg;
    assign sts.out_free   = !out_valid_reg || !out_stall;

    assign root_node = root_reg;
    assign merged    = merged_reg;
    assign out_valid = out_valid_reg;

endmodule

// ===== sv/union_find_engine.sv =====
// Top level of the disjoint-set engine with full path compression.
//
//   channel   direction  handshake               payload
//   request   in         in_valid / in_stall     cmd, first_node, second_node
//   result    out        out_valid / out_stall   root_node, merged
//
// After reset the parent table is cleared, one entry a cycle; in_stall stays
// high meanwhile. A find walks the d links to the root and then rewrites the
// c links on its path, both paced by the single read port of the parent table;
// a union pays the walk for each node. A result waiting on out_stall does not
// block the next request beat until its own result.
module union_find_engine (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      cmd,
    input  logic [uf_pkg::NODE_W-1:0] first_node,
    input  logic [uf_pkg::NODE_W-1:0] second_node,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [uf_pkg::NODE_W-1:0] root_node,
    output logic                      merged
);

    uf_pkg::uf_cmd_t ctl;
    uf_pkg::uf_sts_t sts;

    uf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (ctl)
    );

    uf_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .first_node  (first_node),
        .second_node (second_node),
        .root_node   (root_node),
        .merged      (merged),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .ctl         (ctl),
        .sts         (sts)
    );

endmodule

// ===== bench/uf_tb_pkg.sv =====
`timescale 1ns / 1ps
// Request codes shared by the union-find bench files.
package uf_tb_pkg;

    typedef enum logic {
        OP_FIND  = 1'b0,
        OP_UNION = 1'b1
    } uf_op_e;

    typedef struct packed {
        logic [uf_pkg::NODE_W-1:0] root;
        logic                      joined;
    } root_report_t;

endpackage

// ===== bench/uf_checker.sv =====
`timescale 1ns / 1ps
// Watches both channels of the union-find engine, predicts each result and compares.
module uf_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic                      cmd,
    input  logic [uf_pkg::NODE_W-1:0] first_node,
    input  logic [uf_pkg::NODE_W-1:0] second_node,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic [uf_pkg::NODE_W-1:0] root_node,
    input  logic                      merged,
    output int                        mismatches,
    output int                        owed,
    output int                        finds,
    output int                        unions,
    output int                        merges,
    output int                        longest_walk
);

    localparam int NODES  = uf_pkg::NODES;
    localparam int NODE_W = uf_pkg::NODE_W;

    logic [NODE_W-1:0]          link_of [NODES];
    uf_tb_pkg::root_report_t    owed_q[$];

    // Walk to the root, then point every node on the path straight at it.
    function automatic logic [NODE_W-1:0] find_compress(input logic [NODE_W-1:0] node);
        logic [NODE_W-1:0] top;
        logic [NODE_W-1:0] cur;
        logic [NODE_W-1:0] nxt;
        int                steps;
        if (32'(node) >= NODES)
            return node;
        top = node;
        for (steps = 0; steps < NODES; steps++)
        begin
            nxt = link_of[top];
            if (32'(nxt) >= NODES || nxt == top)
                break;
            top = nxt;
        end
        if (steps > longest_walk)
            longest_walk = steps;
        cur = node;
        for (steps = 0; steps < NODES && cur != top; steps++)
        begin
            nxt = link_of[cur];
            link_of[cur] = top;
            if (32'(nxt) >= NODES)
                break;
            cur = nxt;
        end
        return top;
    endfunction

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        $display("mismatch: %s got %0d want %0d at %0t", what, got_v, want_v, $time);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        uf_tb_pkg::root_report_t got;
        uf_tb_pkg::root_report_t want;
        logic [NODE_W-1:0]       ra;
        logic [NODE_W-1:0]       rb;
        if (!rst_n)
        begin
            for (int i = 0; i < NODES; i++)
                link_of[i] = NODE_W'(i);
            owed_q.delete();
            mismatches   = 0;
            owed         = 0;
            finds        = 0;
            unions       = 0;
            merges       = 0;
            longest_walk = 0;
        end
        else
        begin
            // check the result beat first: it can only belong to an earlier request
            if (out_valid && !out_stall)
            begin
                got.root   = root_node;
                got.joined = merged;
                if (owed_q.size() == 0)
                    report_mismatch("result beat with nothing outstanding, root", got.root, -1);
                else
                begin
                    want = owed_q.pop_front();
                    if (got.root !== want.root)
                        report_mismatch("root_node", got.root, want.root);
                    if (got.joined !== want.joined)
                        report_mismatch("merged", got.joined, want.joined);
                end
            end
            if (in_valid && !in_stall)
            begin
                if (cmd == uf_tb_pkg::OP_UNION)
                begin
                    ra = find_compress(first_node);
                    rb = find_compress(second_node);
                    want.root   = rb;
                    want.joined = (ra != rb) && (32'(ra) < NODES) && (32'(rb) < NODES);
                    if (want.joined)
                    begin
                        link_of[ra] = rb;
                        merges++;
                    end
                    unions++;
                end
                else
                begin
                    want.root   = find_compress(first_node);
                    want.joined = 1'b0;
                    finds++;
                end
                owed_q = {owed_q, want};
            end
            owed = owed_q.size();
        end
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Stimulus, clock, reset and verdict for the union-find engine bench.
module tb_top;

    localparam int NODE_W    = uf_pkg::NODE_W;
    localparam int HOLD_LEN  = 400;
    localparam int HOLD_AT   = 600;
    localparam int PHASES    = 35;
    localparam int PHASE_LEN = 50;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              cmd = 1'b0;
    logic [NODE_W-1:0] first_node = '0;
    logic [NODE_W-1:0] second_node = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [NODE_W-1:0] root_node;
    logic              merged;

    int mismatches;
    int owed;
    int finds;
    int unions;
    int merges;
    int longest_walk;

    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;

    always #5 clk = ~clk;

    union_find_engine u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .first_node  (first_node),
        .second_node (second_node),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .root_node   (root_node),
        .merged      (merged)
    );

    uf_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .first_node   (first_node),
        .second_node  (second_node),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .root_node    (root_node),
        .merged       (merged),
        .mismatches   (mismatches),
        .owed         (owed),
        .finds        (finds),
        .unions       (unions),
        .merges       (merges),
        .longest_walk (longest_walk)
    );

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic offer_request(input uf_tb_pkg::uf_op_e op, input int a, input int b);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    = 1'b1;
        cmd         = op;
        first_node  = NODE_W'(a);
        second_node = NODE_W'(b);
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Result side: random hold-offs, calm stretches, and one long stall.
    initial
    begin : result_side
        int  wait_len;
        int  rx_count;
        bit  hold_done;
        rx_count  = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!hold_done && rx_count == HOLD_AT)
            begin
                out_stall = 1'b1;
                repeat (HOLD_LEN) @(negedge clk);
                hold_done = 1'b1;
            end
            if (rx_count % 100 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            wait_len = rx_calm ? 0 : $urandom_range(0, 12);
            if (wait_len > 0)
            begin
                out_stall = 1'b1;
                repeat (wait_len) @(negedge clk);
            end
            out_stall = 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            rx_count++;
            @(negedge clk);
        end
    end

    initial
    begin : request_side
        int                 base;
        int                 span;
        int                 kind;
        int                 roll;
        int                 a;
        int                 b;
        uf_tb_pkg::uf_op_e  op;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, same-set and self unions, a long chain and its compression
        offer_request(uf_tb_pkg::OP_FIND, 0, 1023);
        offer_request(uf_tb_pkg::OP_FIND, 1023, 0);
        offer_request(uf_tb_pkg::OP_UNION, 0, 1023);
        offer_request(uf_tb_pkg::OP_UNION, 1023, 0);
        offer_request(uf_tb_pkg::OP_UNION, 0, 0);
        offer_request(uf_tb_pkg::OP_UNION, 512, 512);
        for (int k = 100; k < 116; k++)
            offer_request(uf_tb_pkg::OP_UNION, k, k + 1);
        offer_request(uf_tb_pkg::OP_FIND, 100, 1023);
        offer_request(uf_tb_pkg::OP_FIND, 100, 0);
        offer_request(uf_tb_pkg::OP_UNION, 116, 0);

        // random: each phase works a small window of nodes so fresh sets keep appearing
        for (int p = 0; p < PHASES; p++)
        begin
            span    = $urandom_range(4, 64);
            base    = $urandom_range(0, 1024 - span);
            kind    = $urandom_range(0, 3);
            tx_calm = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_LEN; i++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 10 || kind == 3 && roll < 40)
                begin
                    op = uf_tb_pkg::uf_op_e'($urandom_range(0, 1));
                    a  = $urandom_range(0, 1023);
                    b  = $urandom_range(0, 1023);
                end
                else if (kind == 2 && i < span - 1 && i < 25)
                begin
                    // build a chain so later finds walk far
                    op = uf_tb_pkg::OP_UNION;
                    a  = base + i;
                    b  = base + i + 1;
                end
                else
                begin
                    op = (roll < 55) ? uf_tb_pkg::OP_FIND : uf_tb_pkg::OP_UNION;
                    a  = base + $urandom_range(0, span - 1);
                    b  = base + $urandom_range(0, span - 1);
                end
                offer_request(op, a, b);
            end
        end
        in_valid = 1'b0;

        while (owed != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d finds and %0d unions, %0d of which joined two sets",
                 finds, unions, merges);
        $display("deepest walk %0d links; results held off once for %0d cycles",
                 longest_walk, HOLD_LEN);
        if (mismatches == 0 && owed == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== union_find_engine.f =====
sv/uf_pkg.sv
sv/uf_ram.sv
sv/uf_ctrl.sv
sv/uf_dp.sv
sv/union_find_engine.sv
bench/uf_tb_pkg.sv
bench/uf_checker.sv
bench/tb_top.sv
